>>> src/pdp_pkg.sv
// Package for the PWM duty-to-position unit: field widths, reset constants
// and the structs passed between the edge tracker, the serial divider and the top.
// No dependencies.
`default_nettype none

package pdp_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int POSITION_BITS = 14;
  localparam int TIMEOUT_WIDTH = 24;

  localparam int NUM_WIDTH  = COUNT_WIDTH + POSITION_BITS;
  localparam int QCNT_WIDTH = $clog2(POSITION_BITS);

  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(1000000);
  localparam logic [POSITION_BITS-1:0] POS_MAX       = '1;

  typedef struct packed {
    logic                   meas;
    logic                   tmo;
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] high;
  } evt_t;

  typedef struct packed {
    logic                     no_signal;
    logic [POSITION_BITS-1:0] position;
    logic [COUNT_WIDTH-1:0]   period;
    logic [COUNT_WIDTH-1:0]   high;
  } res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> src/pdp_in_if.sv
// Input channel of the PWM duty-to-position unit: one sampled pin level per word.
// Depends on nothing.
`default_nettype none

interface pdp_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

>>> src/pdp_out_if.sv
// Result channel of the PWM duty-to-position unit.
// Depends on pdp_pkg for the field widths.
`default_nettype none

interface pdp_out_if;
  logic                              valid;
  logic                              ready;
  logic [pdp_pkg::POSITION_BITS-1:0] position;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   period_ticks;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   high_ticks;
  logic                              no_signal;

  modport source (output valid, output position, output period_ticks,
                  output high_ticks, output no_signal, input ready);
  modport sink   (input valid, input position, input period_ticks,
                  input high_ticks, input no_signal, output ready);
endinterface

`default_nettype wire

>>> src/pdp_edge_track.sv
// Edge tracker: holds the timeout register, the tick and silence counters and
// the captured high time; flags a measurement or a timeout per accepted word.
// Depends on pdp_pkg.
`default_nettype none

module pdp_edge_track (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic                              pin_level,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pdp_pkg::TIMEOUT_WIDTH-1:0] cfg_wr_data,
  output pdp_pkg::evt_t                          evt
);

  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   edge_counter;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   captured_high;
  logic                              last_level;
  logic                              armed;
  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] silence_counter;

  logic                              rising;
  logic                              falling;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   edge_counter_next;
  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] silence_counter_next;
  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] limit;
  logic                              expired;

  always_comb begin
    rising               = pin_level && !last_level;
    falling              = !pin_level && last_level;
    edge_counter_next    = edge_counter + pdp_pkg::COUNT_WIDTH'(1);
    silence_counter_next = silence_counter + pdp_pkg::TIMEOUT_WIDTH'(1);
    limit                = (timeout_ticks == '0) ? pdp_pkg::TIMEOUT_WIDTH'(1) : timeout_ticks;
    expired              = (silence_counter_next >= limit) || (silence_counter_next == '0);
    evt.meas             = accept && rising && armed;
    evt.tmo              = accept && !rising && expired;
    evt.period           = edge_counter_next;
    evt.high             = captured_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= pdp_pkg::TIMEOUT_RESET;
      edge_counter    <= '0;
      captured_high   <= '0;
      last_level      <= 1'b0;
      armed           <= 1'b0;
      silence_counter <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      if (accept) begin
        last_level <= pin_level;
        if (falling) begin
          captured_high <= edge_counter_next;
        end
        if (rising) begin
          edge_counter    <= '0;
          silence_counter <= '0;
          armed           <= 1'b1;
        end else begin
          edge_counter <= edge_counter_next;
          if (expired) begin
            silence_counter <= '0;
            armed           <= 1'b0;
          end else begin
            silence_counter <= silence_counter_next;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pdp_serial_div.sv
// Bit-serial restoring divider: position = high * POS_MAX / period, one quotient
// bit per cycle from a shift register of the numerator; also stages timeout words.
// Depends on pdp_pkg.
`default_nettype none

module pdp_serial_div (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire pdp_pkg::evt_t evt,
  input  wire logic       take,
  output pdp_pkg::res_t   res,
  output pdp_pkg::div_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                        state;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   rem;
  logic [pdp_pkg::POSITION_BITS-1:0] num_sh;
  logic [pdp_pkg::QCNT_WIDTH-1:0]    cnt;

  logic [pdp_pkg::NUM_WIDTH-1:0]     num;
  logic [pdp_pkg::COUNT_WIDTH:0]     trial;
  logic [pdp_pkg::COUNT_WIDTH:0]     diff;
  logic                              ge;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   rem_next;

  always_comb begin
    num      = {evt.high, pdp_pkg::POSITION_BITS'(0)}
               - pdp_pkg::NUM_WIDTH'(evt.high);
    trial    = {rem, num_sh[pdp_pkg::POSITION_BITS-1]};
    diff     = trial - {1'b0, res.period};
    ge       = trial >= {1'b0, res.period};
    rem_next = ge ? diff[pdp_pkg::COUNT_WIDTH-1:0] : trial[pdp_pkg::COUNT_WIDTH-1:0];
    stat.idle = (state == S_IDLE);
    stat.done = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (evt.tmo) begin
            res.no_signal <= 1'b1;
            res.position  <= '0;
            res.period    <= '0;
            res.high      <= '0;
            state         <= S_DONE;
          end else if (evt.meas) begin
            res.no_signal <= 1'b0;
            res.period    <= evt.period;
            res.high      <= evt.high;
            if (evt.period == '0) begin
              res.position <= '0;
              state        <= S_DONE;
            end else if (evt.high >= evt.period) begin
              res.position <= pdp_pkg::POS_MAX;
              state        <= S_DONE;
            end else begin
              res.position <= '0;
              rem          <= num[pdp_pkg::NUM_WIDTH-1:pdp_pkg::POSITION_BITS];
              num_sh       <= num[pdp_pkg::POSITION_BITS-1:0];
              cnt          <= pdp_pkg::QCNT_WIDTH'(pdp_pkg::POSITION_BITS - 1);
              state        <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rem          <= rem_next;
          num_sh       <= {num_sh[pdp_pkg::POSITION_BITS-2:0], 1'b0};
          res.position <= {res.position[pdp_pkg::POSITION_BITS-2:0], ge};
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - pdp_pkg::QCNT_WIDTH'(1);
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/pwm_duty_to_position_unit.sv
// Top level of the PWM duty-to-position unit: edge tracker, serial divider and
// output register. Depends on pdp_pkg, pdp_in_if, pdp_out_if, pdp_edge_track
// and pdp_serial_div.
//
// Usage: feed one sampled pin level per word on the sample channel. Each
// rising edge after the first yields a result word with the period, the high
// time and position = high * 16383 / period (saturated, 0 for a zero period).
// When timeout_ticks words (at least one) pass with no rising edge, a no-signal
// word with zero fields is produced instead; the next rising edge only re-arms.
// cfg_wr_en/cfg_wr_data write timeout_ticks. Flow: a word that makes no result
// leaves sample.ready high, so the next word can be taken at once. A saturated,
// zero-period or timeout result holds sample.ready low until the output
// register takes it; a measurement that needs a real division also holds it
// low while the serial divider produces one quotient bit per cycle.
// Reset: rst clears all counters, disarms the tracker, loads timeout_ticks
// with 1000000 and empties the output register.
// Stall: a stalled result holds in the output register while further sample
// words are taken; the next result waits in the divider stage and then
// sample.ready drops until the output register frees.
`default_nettype none

module pwm_duty_to_position_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  pdp_in_if.sink                                 sample,
  pdp_out_if.source                              result,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pdp_pkg::TIMEOUT_WIDTH-1:0] cfg_wr_data
);

  pdp_pkg::evt_t      evt;
  pdp_pkg::res_t      res;
  pdp_pkg::div_stat_t stat;
  logic               accept;
  logic               take;
  logic               out_valid;

  assign sample.ready = stat.idle;
  assign accept       = sample.valid && stat.idle;
  assign take         = stat.done && (!out_valid || result.ready);
  assign result.valid = out_valid;

  pdp_edge_track u_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pin_level   (sample.pin_level),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .evt         (evt)
  );

  pdp_serial_div u_div (
    .clk  (clk),
    .rst  (rst),
    .evt  (evt),
    .take (take),
    .res  (res),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.position     <= res.position;
      result.period_ticks <= res.period;
      result.high_ticks   <= res.high;
      result.no_signal    <= res.no_signal;
    end
  end

endmodule

`default_nettype wire

>>> src/pdp_checker.sv
// Port-level checker for the PWM duty-to-position unit, bound to the top level.
// Depends on pdp_pkg and pwm_duty_to_position_unit.
`default_nettype none

module pdp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [pdp_pkg::POSITION_BITS-1:0] position,
  input wire logic [pdp_pkg::COUNT_WIDTH-1:0]   period_ticks,
  input wire logic [pdp_pkg::COUNT_WIDTH-1:0]   high_ticks,
  input wire logic                              no_signal
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position)
      && $stable(period_ticks) && $stable(high_ticks) && $stable(no_signal))
    else $error("stalled result word changed");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_signal |-> position == '0 && period_ticks == '0 && high_ticks == '0)
    else $error("no-signal word carries measurement fields");

  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_signal && period_ticks == '0 |-> position == '0)
    else $error("zero period gives non-zero position");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_signal && period_ticks != '0 && high_ticks >= period_ticks
      |-> position == pdp_pkg::POS_MAX)
    else $error("high time at or above period not saturated");

endmodule

bind pwm_duty_to_position_unit pdp_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .position     (result.position),
  .period_ticks (result.period_ticks),
  .high_ticks   (result.high_ticks),
  .no_signal    (result.no_signal)
);

`default_nettype wire

>>> bench/tb_pwm_duty_to_position_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for pwm_duty_to_position_unit: drives pin samples in bursts,
// predicts every measurement and no-signal word, and checks them as they leave.
// Depends on pdp_pkg, pdp_in_if, pdp_out_if and the unit under test.

module tb_pwm_duty_to_position_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_WORDS   = 600;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_wr_en;
  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] cfg_wr_data;

  pdp_in_if  sample_ch ();
  pdp_out_if result_ch ();

  pwm_duty_to_position_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Predicted tracker state
  logic [pdp_pkg::COUNT_WIDTH-1:0]   trk_count   = '0;
  logic [pdp_pkg::COUNT_WIDTH-1:0]   trk_high    = '0;
  logic                              trk_level   = 1'b0;
  logic                              trk_armed   = 1'b0;
  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] trk_silence = '0;
  logic [pdp_pkg::TIMEOUT_WIDTH-1:0] trk_timeout = pdp_pkg::TIMEOUT_RESET;

  pdp_pkg::res_t awaited_readings[$];
  int   mismatches    = 0;
  int   words_sent    = 0;
  int   burst_left    = 0;
  int   gap_left      = 0;
  int   idle_cycles   = 0;

  int stall_period = 4;
  int stall_len    = 0;
  int stall_pos    = 0;
  int stall_epoch  = 0;

  function automatic logic [pdp_pkg::POSITION_BITS-1:0] scale_duty(
      input logic [pdp_pkg::COUNT_WIDTH-1:0] hi,
      input logic [pdp_pkg::COUNT_WIDTH-1:0] per);
    logic [31:0] q;
    if (per == '0) return '0;
    q = (32'(hi) * 32'(pdp_pkg::POS_MAX)) / 32'(per);
    if (q > 32'(pdp_pkg::POS_MAX)) q = 32'(pdp_pkg::POS_MAX);
    return q[pdp_pkg::POSITION_BITS-1:0];
  endfunction

  function automatic bit decode_tick(input logic level, output pdp_pkg::res_t r);
    logic                              rising;
    logic                              falling;
    logic [pdp_pkg::TIMEOUT_WIDTH-1:0] lim;
    logic [pdp_pkg::COUNT_WIDTH-1:0]   span;
    r       = '0;
    rising  = level & ~trk_level;
    falling = ~level & trk_level;
    lim     = (trk_timeout == '0) ? pdp_pkg::TIMEOUT_WIDTH'(1) : trk_timeout;
    trk_level = level;
    trk_count = trk_count + 1'b1;
    if (falling) trk_high = trk_count;
    if (rising) begin
      span        = trk_count;
      trk_count   = '0;
      trk_silence = '0;
      decode_tick = trk_armed;
      if (trk_armed) begin
        r.position = scale_duty(trk_high, span);
        r.period   = span;
        r.high     = trk_high;
      end
      trk_armed = 1'b1;
      return decode_tick;
    end
    trk_silence = trk_silence + 1'b1;
    if (trk_silence >= lim || trk_silence == '0) begin
      trk_silence = '0;
      trk_armed   = 1'b0;
      r.no_signal = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_word(input logic level);
    pdp_pkg::res_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
      gap_left--;
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.pin_level <= level;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (decode_tick(level, r)) awaited_readings.push_back(r);
    words_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_wave(input int high_len, input int low_len);
    repeat (high_len) send_word(1'b1);
    repeat (low_len) send_word(1'b0);
  endtask

  task automatic drain_results(input bit settle);
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (awaited_readings.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [pdp_pkg::TIMEOUT_WIDTH-1:0] ticks);
    drain_results(1'b1);
    cfg_wr_data <= ticks;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    trk_timeout = ticks;
  endtask

  // Reset timeout: the first rising edge arms only, then the shortest period.
  task automatic test_first_edge();
    send_word(1'b0);
    send_word(1'b0);
    send_wave(1, 1);
    send_wave(3, 4);
    send_wave(5, 2);
    send_word(1'b1);
  endtask

  // Zero, one and two tick timeouts: with zero or one, every tick without a rising edge reports no signal.
  task automatic test_short_timeouts();
    logic [pdp_pkg::TIMEOUT_WIDTH-1:0] ticks;
    for (int i = 0; i < 3; i++) begin
      ticks = pdp_pkg::TIMEOUT_WIDTH'(i);
      write_timeout(ticks);
      send_word(1'b0);
      send_word(1'b0);
      send_wave(2, 1);
      send_wave(1, 3);
      send_word(1'b1);
    end
  endtask

  // Longest timeout: long high and low times and the shortest high time.
  task automatic test_counter_wrap();
    write_timeout('1);
    send_word(1'b0);
    send_wave(120, 1);
    send_wave(1, 120);
    send_wave(60, 60);
    send_wave(1, 1);
    send_word(1'b1);
  endtask

  task automatic test_random_pwm();
    int                                first_word;
    int                                phase;
    int                                kind;
    logic [pdp_pkg::TIMEOUT_WIDTH-1:0] ticks;
    first_word = words_sent;
    phase      = 0;
    while (words_sent - first_word < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       ticks = pdp_pkg::TIMEOUT_WIDTH'(1);
        1:       ticks = '1;
        2:       ticks = pdp_pkg::TIMEOUT_WIDTH'($urandom_range(0, 24'hFFFFFF));
        default: ticks = pdp_pkg::TIMEOUT_WIDTH'($urandom_range(4, 80));
      endcase
      write_timeout(ticks);
      repeat ($urandom_range(4, 12)) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) send_wave($urandom_range(1, 24), $urandom_range(1, 24));
        else if (kind < 9) repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(0, 1)));
        else repeat ($urandom_range(1, 100)) send_word(trk_level);
        if (phase == 1 && kind == 0) drain_results(1'b0);
      end
      phase++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_epoch == 0) begin
      stall_epoch  = $urandom_range(50, 300);
      stall_period = $urandom_range(2, 16);
      stall_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      stall_pos    = 0;
    end
    result_ch.ready <= (stall_pos >= stall_len);
    stall_pos = (stall_pos + 1) % stall_period;
    stall_epoch--;
  end

  always @(posedge clk) begin : check_results
    pdp_pkg::res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_readings.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        want = awaited_readings.pop_front();
        if (result_ch.no_signal !== want.no_signal) begin
          $error("no_signal: expected %0d, got %0d", want.no_signal, result_ch.no_signal);
          mismatches++;
        end
        if (result_ch.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, result_ch.position);
          mismatches++;
        end
        if (result_ch.period_ticks !== want.period) begin
          $error("period_ticks: expected %0d, got %0d", want.period, result_ch.period_ticks);
          mismatches++;
        end
        if (result_ch.high_ticks !== want.high) begin
          $error("high_ticks: expected %0d, got %0d", want.high, result_ch.high_ticks);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sample_ch.valid     = 1'b0;
    sample_ch.pin_level = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_edge();
    test_short_timeouts();
    test_counter_wrap();
    test_random_pwm();

    drain_results(1'b0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
